[rtl/koch_snowflake_segment_generator_unit_macros.svh]
// assertion helpers shared by the rtl files
`ifndef KOCH_SNOWFLAKE_SEGMENT_GENERATOR_UNIT_MACROS_SVH
`define KOCH_SNOWFLAKE_SEGMENT_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define KSG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ksg_pkg.sv]
package ksg_pkg;

  localparam int KSG_MAX_DEPTH = 11;
  localparam int FRAC_BITS     = 16;
  localparam int PIX_W         = 16;
  localparam int POS_W         = PIX_W + FRAC_BITS;
  localparam int STEP_W        = 11 + FRAC_BITS;
  localparam int DEPTH_W       = 4;
  localparam int SIDE_W        = 10;
  localparam int ORIG_W        = 12;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;

  // divide by three: x * ceil(2^29 / 3) >> 29 is exact for x < 2^27
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP3 = 28'd178956971;

  // sqrt(3)/2 in q.28
  localparam int SQRT3_SHIFT = 28;
  localparam logic [RECIP_W-1:0] SQRT3_HALF = 28'd232471924;

  localparam int PROD_W = STEP_W + RECIP_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH    = 2'd0,
    REG_SIDE     = 2'd1,
    REG_ORIGIN_X = 2'd2,
    REG_ORIGIN_Y = 2'd3
  } cfg_reg_t;

  // headings in sixths of a turn, y axis down
  localparam logic [2:0] HD_E  = 3'd0;
  localparam logic [2:0] HD_NE = 3'd1;
  localparam logic [2:0] HD_NW = 3'd2;
  localparam logic [2:0] HD_W  = 3'd3;
  localparam logic [2:0] HD_SW = 3'd4;
  localparam logic [2:0] HD_SE = 3'd5;

  typedef struct packed {
    logic load;
    logic div;
    logic tall;
    logic emit;
  } ksg_cmd_t;

  typedef struct packed {
    logic div_zero;
    logic last;
    logic slot_free;
  } ksg_stat_t;

endpackage

[rtl/ksg_ifs.sv]
interface ksg_in_if import ksg_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface ksg_out_if import ksg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] from_x;
  logic signed [PIX_W-1:0] from_y;
  logic signed [PIX_W-1:0] to_x;
  logic signed [PIX_W-1:0] to_y;
  logic                    last_segment;

  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  output last_segment, input ready);
  modport sink   (input valid, input from_x, input from_y, input to_x, input to_y,
                  input last_segment, output ready);
endinterface

[rtl/ksg_ctrl.sv]
`include "koch_snowflake_segment_generator_unit_macros.svh"

module ksg_ctrl import ksg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ksg_in_if.sink    in_chan,
  input  ksg_stat_t st,
  output ksg_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCALE = 4'b0010,
    S_TALL  = 4'b0100,
    S_RUN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready;
  logic   acc;

  // idle takes anything, a run takes beats while the output slot is free
  assign in_ready      = (state_r == S_IDLE) || ((state_r == S_RUN) && st.slot_free);
  assign in_chan.ready = in_ready;
  assign acc           = in_chan.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc && in_chan.restart) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (st.div_zero) begin
          state_nxt = S_TALL;
        end else begin
          cmd.div = 1'b1;
        end
      end
      S_TALL: begin
        cmd.tall  = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (acc) begin
          if (in_chan.restart) begin
            cmd.load  = 1'b1;
            state_nxt = S_SCALE;
          end else begin
            cmd.emit = 1'b1;
            if (st.last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `KSG_ASSERT_NEXT(a_restart_scales, acc && in_chan.restart, state_r == S_SCALE, "restart not scaling")
  `KSG_ASSERT_NEXT(a_scale_to_tall, state_r == S_SCALE && st.div_zero, state_r == S_TALL, "scale stuck")
  `KSG_ASSERT_NEXT(a_last_idles, cmd.emit && st.last, state_r == S_IDLE, "run past last segment")

endmodule

[rtl/ksg_dp.sv]
`include "koch_snowflake_segment_generator_unit_macros.svh"

module ksg_dp import ksg_pkg::*; #(
  parameter int MAX_DEPTH = KSG_MAX_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ksg_cmd_t              cmd,
  output ksg_stat_t             st,
  ksg_out_if.source             out_chan
);

  localparam int IDX_W = 2 * MAX_DEPTH;

  function automatic logic [PIX_W-1:0] to_pixel(input logic [POS_W-1:0] p);
    logic             neg;
    logic [POS_W-1:0] mag;
    logic [PIX_W-1:0] px;
    neg = p[POS_W-1];
    mag = neg ? (~p + POS_W'(1)) : p;
    px  = mag[FRAC_BITS +: PIX_W];
    return neg ? (~px + PIX_W'(1)) : px;
  endfunction

  // configuration registers
  logic [DEPTH_W-1:0] depth_r;
  logic [SIDE_W-1:0]  side_r;
  logic [ORIG_W-1:0]  orig_x_r;
  logic [ORIG_W-1:0]  orig_y_r;

  // run state
  logic [DEPTH_W-1:0] run_depth_r;
  logic [DEPTH_W-1:0] div_cnt_r;
  logic [STEP_W-1:0]  step_r;
  logic [STEP_W-1:0]  half_r;
  logic [STEP_W-1:0]  tall_r;
  logic [POS_W-1:0]   pos_x_r;
  logic [POS_W-1:0]   pos_y_r;
  logic [2:0]         heading_r;
  logic [IDX_W-1:0]   idx_r;

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] from_x_r, from_y_r, to_x_r, to_y_r;
  logic             last_r;

  logic [DEPTH_W-1:0] depth_clamp;
  logic [PROD_W-1:0]  div_prod;
  logic [PROD_W-1:0]  tall_prod;
  logic [1:0]         digit;
  logic [2:0]         hd_turn;
  logic [2:0]         hd_new;
  logic [POS_W-1:0]   dx, dy, nx, ny;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   total;

  always_comb begin
    if (depth_r == '0) begin
      depth_clamp = DEPTH_W'(1);
    end else if (depth_r > DEPTH_W'(MAX_DEPTH)) begin
      depth_clamp = DEPTH_W'(MAX_DEPTH);
    end else begin
      depth_clamp = depth_r;
    end
  end

  assign div_prod  = PROD_W'(step_r) * PROD_W'(RECIP3);
  assign tall_prod = PROD_W'(step_r) * PROD_W'(SQRT3_HALF) + (PROD_W'(1) << (SQRT3_SHIFT - 1));

  // lowest nonzero base-4 digit of the index within a side
  always_comb begin
    digit = 2'd0;
    for (int i = MAX_DEPTH - 2; i >= 0; i--) begin
      if (i < (int'(run_depth_r) - 1) && idx_r[2*i +: 2] != 2'd0) begin
        digit = idx_r[2*i +: 2];
      end
    end
  end

  always_comb begin
    if (digit == 2'd0 || digit == 2'd2) begin
      hd_turn = (heading_r >= 3'd2) ? heading_r - 3'd2 : heading_r + 3'd4;
    end else begin
      hd_turn = (heading_r == HD_SE) ? HD_E : heading_r + 3'd1;
    end
    hd_new = (idx_r != '0) ? hd_turn : heading_r;
  end

  always_comb begin
    case (hd_new)
      HD_E: begin
        dx = POS_W'(step_r);
        dy = '0;
      end
      HD_NE: begin
        dx = POS_W'(half_r);
        dy = '0 - POS_W'(tall_r);
      end
      HD_NW: begin
        dx = '0 - POS_W'(half_r);
        dy = '0 - POS_W'(tall_r);
      end
      HD_W: begin
        dx = '0 - POS_W'(step_r);
        dy = '0;
      end
      HD_SW: begin
        dx = '0 - POS_W'(half_r);
        dy = POS_W'(tall_r);
      end
      default: begin
        dx = POS_W'(half_r);
        dy = POS_W'(tall_r);
      end
    endcase
  end

  assign nx      = pos_x_r + dx;
  assign ny      = pos_y_r + dy;
  assign idx_inc = idx_r + IDX_W'(1);
  assign total   = IDX_W'(3) << {run_depth_r - DEPTH_W'(1), 1'b0};

  assign st.div_zero  = (div_cnt_r == '0);
  assign st.last      = (idx_inc >= total);
  assign st.slot_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= DEPTH_W'(4);
      side_r   <= SIDE_W'(185);
      orig_x_r <= ORIG_W'(230);
      orig_y_r <= ORIG_W'(190);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH:    depth_r  <= cfg_wdata[DEPTH_W-1:0];
        REG_SIDE:     side_r   <= cfg_wdata[SIDE_W-1:0];
        REG_ORIGIN_X: orig_x_r <= cfg_wdata[ORIG_W-1:0];
        REG_ORIGIN_Y: orig_y_r <= cfg_wdata[ORIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_depth_r <= DEPTH_W'(1);
      div_cnt_r   <= '0;
      heading_r   <= HD_NE;
      idx_r       <= '0;
    end else if (cmd.load) begin
      run_depth_r <= depth_clamp;
      div_cnt_r   <= depth_clamp - DEPTH_W'(1);
      heading_r   <= HD_NE;
      idx_r       <= '0;
    end else if (cmd.div) begin
      div_cnt_r <= div_cnt_r - DEPTH_W'(1);
    end else if (cmd.emit) begin
      heading_r <= hd_new;
      idx_r     <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step_r  <= STEP_W'(side_r) << FRAC_BITS;
      pos_x_r <= POS_W'(orig_x_r) << FRAC_BITS;
      pos_y_r <= POS_W'(orig_y_r) << FRAC_BITS;
    end else if (cmd.div) begin
      step_r <= div_prod[RECIP_SHIFT +: STEP_W];
    end else if (cmd.emit) begin
      pos_x_r <= nx;
      pos_y_r <= ny;
    end
    if (cmd.tall) begin
      half_r <= STEP_W'((STEP_W'(1) + step_r) >> 1) | (step_r == {STEP_W{1'b1}} ?
                (STEP_W'(1) << (STEP_W - 1)) : STEP_W'(0));
      tall_r <= tall_prod[SQRT3_SHIFT +: STEP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      from_x_r <= to_pixel(pos_x_r);
      from_y_r <= to_pixel(pos_y_r);
      to_x_r   <= to_pixel(nx);
      to_y_r   <= to_pixel(ny);
      last_r   <= st.last;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.from_x       = from_x_r;
  assign out_chan.from_y       = from_y_r;
  assign out_chan.to_x         = to_x_r;
  assign out_chan.to_y         = to_y_r;
  assign out_chan.last_segment = last_r;

  `KSG_ASSERT_NEXT(a_emit_fills, cmd.emit, out_valid_r, "emitted beat lost")
  `KSG_ASSERT_NEXT(a_load_init, cmd.load, idx_r == '0 && heading_r == HD_NE, "restart init wrong")
  `KSG_ASSERT_NEXT(a_div_count, cmd.div, div_cnt_r == $past(div_cnt_r) - DEPTH_W'(1), "scale count slip")

endmodule

[rtl/koch_snowflake_segment_generator_unit.sv]
// channel   dir  beat payload                               handshake
// in_chan   in   restart                                    valid / ready
// out_chan  out  from_x, from_y, to_x, to_y, last_segment   valid / ready
// cfg_*     in   cfg_index, cfg_wdata                       cfg_we, no wait
//
// a restart beat holds the input off through the scale and tall steps:
//   depth - 1 (clamped depth) divide-by-three passes of the step length
//   through the reciprocal multiplier, a pass count check, the tall step
// in a run with a free output slot, one tick beat per cycle goes into it
// rst_n is synchronous, active low; config comes back to its reset values
// a stalled output register holds off further ticks until it is taken

module koch_snowflake_segment_generator_unit import ksg_pkg::*; #(
  parameter int MAX_DEPTH = KSG_MAX_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ksg_in_if.sink                in_chan,
  ksg_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // commands from the sequencer, status back from the datapath
  ksg_cmd_t  cmd;
  ksg_stat_t st;

  // sequencer: idle, scale, tall step, run
  ksg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .st      (st),
    .cmd     (cmd)
  );

  // datapath: config, step scaling, turtle position, output register
  ksg_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_chan  (out_chan)
  );

endmodule
